>>> src/rrov_pkg.sv
package rrov_pkg;

	// field widths fixed by the outline format
	localparam int IDX_W   = 10;
	localparam int PPC_W   = 9;
	localparam int TOTAL_W = 11;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;

	// quarter-turn phase, Q0.16 with room for 1.0
	localparam int PHASE_W = 17;
	localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;

	// sin(pi/2 * x) Taylor magnitudes, Q30
	localparam int POLY_W = 31;
	localparam logic [POLY_W-1:0] SIN_C1 = 31'd1686629713;
	localparam logic [POLY_W-1:0] SIN_C3 = 31'd693598668;
	localparam logic [POLY_W-1:0] SIN_C5 = 31'd85569305;
	localparam logic [POLY_W-1:0] SIN_C7 = 31'd5026995;
	localparam logic [POLY_W-1:0] SIN_C9 = 31'd172272;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_PPC    = 2'd3;

	// corner codes
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

endpackage

>>> src/rrov_if.sv
interface rrov_req_if import rrov_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] point_index;

	modport source (output valid, output point_index, input ready);
	modport sink (input valid, input point_index, output ready);
endinterface

interface rrov_rsp_if import rrov_pkg::*; #(
	parameter int COORD_BITS = 16
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] vertex_x;
	logic [COORD_BITS-1:0] vertex_y;
	logic [TOTAL_W-1:0]    total_points;
	logic                  index_out_of_range;

	modport source (output valid, output vertex_x, output vertex_y, output total_points,
		output index_out_of_range, input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input total_points,
		input index_out_of_range, output ready);
endinterface

>>> src/rrov_ram.sv
module rrov_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> src/rrov_sine.sv
module rrov_sine import rrov_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [PHASE_W-1:0]   phase,
	output logic [FRAC_BITS:0]   sine
);
	localparam int PROD_W = PHASE_W + POLY_W;
	localparam int SW     = FRAC_BITS + 1;
	localparam logic [PROD_W-1:0] RND  = PROD_W'(1) << (45 - FRAC_BITS);
	localparam logic [PROD_W-1:0] TOP  = PROD_W'(1) << FRAC_BITS;

	logic [PHASE_W-1:0] t_a, t_b, t_c, t_d, t_e;
	logic [PHASE_W-1:0] x2_a, x2_b, x2_c, x2_d;
	logic [POLY_W-1:0]  p_b, p_c, p_d, p_e;
	logic [2*PHASE_W-1:0] sq;
	logic [PROD_W-1:0]  fin, fin_sh;

	function automatic logic [POLY_W-1:0] horner(input logic [PHASE_W-1:0] x2,
		input logic [POLY_W-1:0] p, input logic [POLY_W-1:0] c);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(x2) * PROD_W'(p);
		return c - POLY_W'(prod >> 16);
	endfunction

	assign sq     = (2*PHASE_W)'(phase) * (2*PHASE_W)'(phase) + (2*PHASE_W)'(32768);
	assign fin    = PROD_W'(t_e) * PROD_W'(p_e) + RND;
	assign fin_sh = fin >> (46 - FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			t_a  <= phase;
			x2_a <= PHASE_W'(sq >> 16);
			t_b  <= t_a;
			x2_b <= x2_a;
			p_b  <= horner(x2_a, SIN_C9, SIN_C7);
			t_c  <= t_b;
			x2_c <= x2_b;
			p_c  <= horner(x2_b, p_b, SIN_C5);
			t_d  <= t_c;
			x2_d <= x2_c;
			p_d  <= horner(x2_c, p_c, SIN_C3);
			t_e  <= t_d;
			p_e  <= horner(x2_d, p_d, SIN_C1);
			sine <= (fin_sh > TOP) ? SW'(TOP) : SW'(fin_sh);
		end
	end
endmodule

>>> src/rounded_rect_outline_vertex.sv
// channel  | dir | payload                                          | accepted when
// ---------+-----+--------------------------------------------------+------------------
// req      | in  | point_index                                      | valid && ready
// rsp      | out | vertex_x, vertex_y, total_points, index_out_of_range | valid && ready
// apb      | in  | width, height, radius, points per corner         | psel&penable&pwrite
//
// One request per cycle while ready is high; each result reaches the output register
// via the request register, phase table read, six-stage sine pipeline, scale and offset.
// After reset and after each points_per_corner write, the phase table is rebuilt:
// a bit-serial reciprocal division, then one table entry per arc point, with ready low.
// A stalled output holds the pipeline only once its last stage is occupied.
module rounded_rect_outline_vertex import rrov_pkg::*; #(
	parameter int MAX_POINTS_PER_CORNER = 256,
	parameter int COORD_BITS            = 16,
	parameter int TRIG_FRACTION_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rrov_req_if.sink          req,
	rrov_rsp_if.source        rsp
);
	localparam int W    = COORD_BITS;
	localparam int F    = TRIG_FRACTION_BITS;
	localparam int VW   = W + F + 2;
	localparam int AW   = $clog2(MAX_POINTS_PER_CORNER);
	localparam int NCAP = (MAX_POINTS_PER_CORNER < 511) ? MAX_POINTS_PER_CORNER : 511;
	localparam int DLY  = 5;

	localparam logic [1:0] ST_DIV  = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	typedef struct packed {
		logic          vld;
		logic [1:0]    corner;
		logic          oor;
		logic [VW-1:0] cxr;
		logic [VW-1:0] cyr;
	} side_t;

	// configuration
	logic [W-1:0]     width_q, height_q, radius_q;
	logic [PPC_W-1:0] ppc_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			radius_q <= '0;
			ppc_q    <= PPC_W'(2);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[W-1:0];
				REG_HEIGHT: height_q <= pwdata[W-1:0];
				REG_RADIUS: radius_q <= pwdata[W-1:0];
				REG_PPC:    ppc_q    <= pwdata[PPC_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_RADIUS: prdata = APB_DW'(radius_q);
			REG_PPC:    prdata = APB_DW'(ppc_q);
			default:    prdata = '0;
		endcase
	end

	// effective points per corner and derived geometry
	logic [PPC_W-1:0]   n_eff, dvs;
	logic [TOTAL_W-1:0] n1_q, n2_q, n3_q, tot_q;
	logic [W:0]         r2_q, rr, shorter_half;

	always_comb begin
		priority if (ppc_q < PPC_W'(2)) begin
			n_eff = PPC_W'(2);
		end else if (32'(ppc_q) > NCAP) begin
			n_eff = PPC_W'(NCAP);
		end else begin
			n_eff = ppc_q;
		end
	end

	assign dvs          = n_eff - PPC_W'(1);
	assign rr           = {radius_q, 1'b0};
	assign shorter_half = (width_q < height_q) ? {1'b0, width_q} : {1'b0, height_q};

	always_ff @(posedge clk) begin
		n1_q  <= TOTAL_W'(n_eff);
		n2_q  <= TOTAL_W'({n_eff, 1'b0});
		n3_q  <= TOTAL_W'(n_eff) + TOTAL_W'({n_eff, 1'b0});
		tot_q <= {n_eff, 2'b00};
		r2_q  <= (rr > shorter_half) ? shorter_half : rr;
	end

	// phase table build: 65536 / (n-1) once, then t(p) stepped by quotient and remainder
	logic [1:0]         st_q;
	logic [4:0]         cnt_q;
	logic [PPC_W-1:0]   rem_q, frem_q;
	logic [PHASE_W-1:0] quo_q, fq_q;
	logic [AW-1:0]      fa_q;
	logic [PPC_W:0]     div_sh, fsum;
	logic               div_ge, fge;

	assign div_sh = {rem_q, (cnt_q == 5'd0)};
	assign div_ge = div_sh >= {1'b0, dvs};
	assign fsum   = {1'b0, frem_q} + {1'b0, rem_q};
	assign fge    = fsum >= {1'b0, dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_DIV;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			fq_q   <= '0;
			frem_q <= '0;
			fa_q   <= '0;
		end else if (cfg_wr && paddr[3:2] == REG_PPC) begin
			st_q  <= ST_DIV;
			cnt_q <= '0;
			rem_q <= '0;
		end else begin
			unique case (st_q)
				ST_DIV: begin
					rem_q <= div_ge ? PPC_W'(div_sh - {1'b0, dvs}) : PPC_W'(div_sh);
					quo_q <= {quo_q[PHASE_W-2:0], div_ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(PHASE_W - 1)) begin
						st_q   <= ST_FILL;
						fq_q   <= '0;
						frem_q <= dvs >> 1;
						fa_q   <= '0;
					end
				end
				ST_FILL: begin
					if (32'(fa_q) == 32'(dvs)) begin
						st_q <= ST_RUN;
					end
					fa_q   <= fa_q + AW'(1);
					fq_q   <= fq_q + quo_q + PHASE_W'(fge);
					frem_q <= fge ? PPC_W'(fsum - {1'b0, dvs}) : PPC_W'(fsum);
				end
				ST_RUN: ;
				default: st_q <= ST_RUN;
			endcase
		end
	end

	// pipeline control
	logic          adv;
	logic          vld_s1, vld_s2;
	logic          out_vld_q;
	side_t         side_s3, side_s9;
	side_t         side_dly_q [DLY];

	assign adv       = !side_s9.vld || !out_vld_q || rsp.ready;
	assign req.ready = (st_q == ST_RUN) && adv;

	// s1: request register
	logic [IDX_W-1:0] idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid && req.ready;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= req.point_index;
		end
	end

	// s1 -> s2: corner split by compare against n, 2n, 3n
	logic [TOTAL_W-1:0] idx_w, base, pos_w;
	logic [1:0]         corner_c, corner_s2;
	logic               oor_c, oor_s2;
	logic [AW-1:0]      rd_addr;

	assign idx_w = TOTAL_W'(idx_s1);
	assign oor_c = idx_w >= tot_q;

	always_comb begin
		priority if (idx_w >= n3_q) begin
			corner_c = CORNER_BL;
			base     = n3_q;
		end else if (idx_w >= n2_q) begin
			corner_c = CORNER_BR;
			base     = n2_q;
		end else if (idx_w >= n1_q) begin
			corner_c = CORNER_TR;
			base     = n1_q;
		end else begin
			corner_c = CORNER_TL;
			base     = '0;
		end
	end

	assign pos_w   = idx_w - base;
	assign rd_addr = oor_c ? '0 : pos_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			corner_s2 <= corner_c;
			oor_s2    <= oor_c;
		end
	end

	logic [PHASE_W-1:0] t_s2;

	rrov_ram #(
		.WIDTH (PHASE_W),
		.DEPTH (MAX_POINTS_PER_CORNER)
	) u_phase_ram (
		.clk     (clk),
		.wr_en   (st_q == ST_FILL),
		.wr_addr (fa_q),
		.wr_data (fq_q),
		.rd_en   (adv),
		.rd_addr (rd_addr),
		.rd_data (t_s2)
	);

	// s2: inset centre, pre-biased by the rounding half
	logic [W:0]    cx, cy;
	side_t         side_c;

	always_comb begin
		cx = (corner_s2 == CORNER_TR || corner_s2 == CORNER_BR) ?
			({width_q, 1'b0} - r2_q) : r2_q;
		cy = (corner_s2 == CORNER_BR || corner_s2 == CORNER_BL) ?
			({height_q, 1'b0} - r2_q) : r2_q;
		side_c.vld    = vld_s2;
		side_c.corner = corner_s2;
		side_c.oor    = oor_s2;
		side_c.cxr    = (VW'(cx) << F) + (VW'(1) << F);
		side_c.cyr    = (VW'(cy) << F) + (VW'(1) << F);
	end

	// s3..s8: sine and cosine pipelines
	logic [F:0] sn_s8, cs_s8;

	rrov_sine #(.FRAC_BITS (F)) u_sin (
		.clk   (clk),
		.en    (adv),
		.phase (t_s2),
		.sine  (sn_s8)
	);

	rrov_sine #(.FRAC_BITS (F)) u_cos (
		.clk   (clk),
		.en    (adv),
		.phase (PHASE_ONE - t_s2),
		.sine  (cs_s8)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
			side_s9 <= '0;
			for (int i = 0; i < DLY; i++) begin
				side_dly_q[i] <= '0;
			end
		end else if (adv) begin
			side_s3       <= side_c;
			side_dly_q[0] <= side_s3;
			for (int i = 1; i < DLY; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
			side_s9 <= side_dly_q[DLY-1];
		end
	end

	// s9: radius times sine and cosine
	logic [VW-1:0] off_s_s9, off_c_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s_s9 <= VW'(r2_q) * VW'(sn_s8);
			off_c_s9 <= VW'(r2_q) * VW'(cs_s8);
		end
	end

	// s9 -> output register: offset from centre and round to an unsigned integer (Q16.0 at default COORD_BITS)
	logic [VW-1:0] vx, vy;

	always_comb begin
		unique case (side_s9.corner)
			CORNER_TL: begin
				vx = side_s9.cxr - off_c_s9;
				vy = side_s9.cyr - off_s_s9;
			end
			CORNER_TR: begin
				vx = side_s9.cxr + off_s_s9;
				vy = side_s9.cyr - off_c_s9;
			end
			CORNER_BR: begin
				vx = side_s9.cxr + off_c_s9;
				vy = side_s9.cyr + off_s_s9;
			end
			CORNER_BL: begin
				vx = side_s9.cxr - off_s_s9;
				vy = side_s9.cyr + off_c_s9;
			end
			default: begin
				vx = '0;
				vy = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && side_s9.vld) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	logic [W-1:0]       vx_q, vy_q;
	logic [TOTAL_W-1:0] tot_out_q;
	logic               oor_q;

	always_ff @(posedge clk) begin
		if (adv && side_s9.vld) begin
			vx_q      <= side_s9.oor ? '0 : vx[F+1 +: W];
			vy_q      <= side_s9.oor ? '0 : vy[F+1 +: W];
			tot_out_q <= tot_q;
			oor_q     <= side_s9.oor;
		end
	end

	assign rsp.valid              = out_vld_q;
	assign rsp.vertex_x           = vx_q;
	assign rsp.vertex_y           = vy_q;
	assign rsp.total_points       = tot_out_q;
	assign rsp.index_out_of_range = oor_q;

endmodule
